[sv/ppmdec_pkg.sv]
`default_nettype none

package ppmdec_pkg;

	// decoder geometry
	localparam int CHANNELS      = 8;
	localparam int ANALOG_INPUTS = 2;
	localparam int REPORT_LEN    = 1 + 2 * CHANNELS + 2 * ANALOG_INPUTS;

	localparam int WORD_W = 16;
	localparam int BYTE_W = 8;
	localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IDX_W  = $clog2(CHANNELS + 1);
	localparam int K_W    = $clog2(REPORT_LEN);

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_OFFSET   = CFG_IDX_W'(1);

	localparam logic [WORD_W-1:0] SYNC_THRESHOLD_RST = WORD_W'(20000);
	localparam logic [WORD_W-1:0] PULSE_OFFSET_RST   = WORD_W'(2000);

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} rpt_state_t;

	typedef struct packed {
		logic              en;
		logic [CH_AW-1:0]  addr;
		logic [WORD_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic             en;
		logic [CH_AW-1:0] addr;
	} rd_req_t;

endpackage

`default_nettype wire

[sv/ppmdec_if.sv]
`default_nettype none

interface ppmdec_item_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] interval;
	logic [7:0]  buttons;
	logic [15:0] analog_a;
	logic [15:0] analog_b;

	modport source (output valid, mode, interval, buttons, analog_a, analog_b, input ready);
	modport sink   (input valid, mode, interval, buttons, analog_a, analog_b, output ready);
endinterface

interface ppmdec_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] report_byte;
	logic       last_byte;

	modport source (output valid, report_byte, last_byte, input ready);
	modport sink   (input valid, report_byte, last_byte, output ready);
endinterface

interface ppmdec_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/ppmdec_store.sv]
`default_nettype none

module ppmdec_store
	import ppmdec_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wr_req_t           wr,
	input  wire rd_req_t           rd,
	output logic [WORD_W-1:0]      rdata
);

	logic [WORD_W-1:0] mem_q [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	logic [WORD_W-1:0] rdata_q;

	// per-entry valid bits stand in for the all-zero reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= vld_q[rd.addr] ? mem_q[rd.addr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/ppmdec_edge.sv]
`default_nettype none

module ppmdec_edge
	import ppmdec_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [WORD_W-1:0] interval,
	input  wire logic [WORD_W-1:0] threshold,
	output wr_req_t                wr
);

	logic [IDX_W-1:0] idx_q;
	logic             pause_q;
	logic             is_sync;
	logic             has_room;

	assign is_sync  = interval > threshold;
	assign has_room = idx_q < IDX_W'(CHANNELS);

	always_comb begin
		wr.en   = take && !is_sync && !pause_q && has_room;
		wr.addr = idx_q[CH_AW-1:0];
		wr.data = interval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pause_q <= 1'b0;
		end else if (take) begin
			if (is_sync) begin
				idx_q   <= '0;
				pause_q <= 1'b1;
			end else if (pause_q) begin
				pause_q <= 1'b0;
			end else begin
				if (has_room) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				pause_q <= 1'b1;
			end
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(CHANNELS))
		else $error("channel index beyond slot count");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> idx_q == $past(idx_q) + IDX_W'(1))
		else $error("stored pulse did not advance the index");

	a_sync_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_sync |=> idx_q == '0 && pause_q)
		else $error("frame sync did not rewind");

endmodule

`default_nettype wire

[sv/ppmdec_report.sv]
`default_nettype none

module ppmdec_report
	import ppmdec_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [BYTE_W-1:0] buttons,
	input  wire logic [WORD_W-1:0] analog_a,
	input  wire logic [WORD_W-1:0] analog_b,
	input  wire logic [WORD_W-1:0] offset,
	input  wire logic [WORD_W-1:0] rdata,
	output rd_req_t                rd,
	output logic                   busy,
	ppmdec_byte_if.source          rpt
);

	rpt_state_t state_q, state_d;

	logic [K_W-1:0]    k_q;
	logic [BYTE_W-1:0] buttons_q;
	logic [WORD_W-1:0] analog_q [2];
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              out_free;
	logic              emit;
	logic              is_last;
	logic [K_W-1:0]    pos;
	logic [K_W-1:0]    pos_an;
	logic [WORD_W-1:0] diff;
	logic [WORD_W-1:0] an_word;
	logic [BYTE_W-1:0] byte_d;

	assign out_free = !out_valid_q || rpt.ready;
	assign is_last  = k_q == K_W'(REPORT_LEN - 1);
	assign pos      = k_q - K_W'(1);
	assign pos_an   = pos - K_W'(2 * CHANNELS);
	assign diff     = rdata - offset;
	assign an_word  = analog_q[pos_an[1]];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_SEND;
			ST_SEND: if (emit && is_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy    = state_q == ST_SEND;
		emit    = busy && out_free;
		// fetch the next channel word while its preceding byte goes out
		rd.en   = emit && !k_q[0] && (k_q[K_W-1:1] < (K_W-1)'(CHANNELS));
		rd.addr = k_q[CH_AW:1];
		if (k_q == '0) begin
			byte_d = buttons_q;
		end else if (k_q <= K_W'(2 * CHANNELS)) begin
			byte_d = pos[0] ? diff[15:8] : diff[7:0];
		end else begin
			byte_d = pos[0] ? an_word[15:8] : an_word[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				k_q <= '0;
			end else if (emit) begin
				k_q <= k_q + K_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rpt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			buttons_q   <= buttons;
			analog_q[0] <= analog_a;
			analog_q[1] <= analog_b;
		end
		if (emit) begin
			out_byte_q <= byte_d;
			out_last_q <= is_last;
		end
	end

	assign rpt.valid       = out_valid_q;
	assign rpt.report_byte = out_byte_q;
	assign rpt.last_byte   = out_last_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("report started while serialising");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd.en |-> state_q == ST_SEND && out_free)
		else $error("store read outside a report");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_last |=> state_q == ST_IDLE && rpt.valid && rpt.last_byte)
		else $error("final byte did not close the report");

	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !is_last |=> !rpt.last_byte)
		else $error("last flag on an inner byte");

endmodule

`default_nettype wire

[sv/ppm_channel_decoder_with_report_top.sv]
// channel   role    payload                                      transfer when
// item      sink    mode, interval, buttons, analog_a, analog_b  item.valid & item.ready
// report    source  report_byte, last_byte                       report.valid & report.ready
// cfg       sink    index, data                                  cfg.valid (ready always high)
//
// an edge item is decoded and written to the store at its transfer
// a report item serialises 21 bytes at one per cycle unless stalled, set by the single
// output register, and one store read per channel, fetched while the previous byte goes out
// item.ready stays low while a report is being serialised; it is high again once the
// final byte sits in the output register, even if that byte is still stalled
// arst_n clears the index, pause flag, store valid bits and the output valid flag
`default_nettype none

module ppm_channel_decoder_with_report_top
	import ppmdec_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	ppmdec_item_if.sink   item,
	ppmdec_byte_if.source report,
	ppmdec_cfg_if.sink    cfg
);

	logic [WORD_W-1:0] thr_q;
	logic [WORD_W-1:0] off_q;

	logic              busy;
	logic              take;
	logic              take_edge;
	logic              take_report;
	wr_req_t           wr;
	rd_req_t           rd;
	logic [WORD_W-1:0] rdata;

	// configuration writes are always taken; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= SYNC_THRESHOLD_RST;
			off_q <= PULSE_OFFSET_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SYNC_THRESHOLD: thr_q <= cfg.data;
				CFG_PULSE_OFFSET:   off_q <= cfg.data;
				default:            ;
			endcase
		end
	end

	// no item is taken while the serialiser runs, so the store never sees
	// a write during a report
	assign item.ready  = !busy;
	assign take        = item.valid && item.ready;
	assign take_edge   = take && !item.mode;
	assign take_report = take && item.mode;

	ppmdec_edge u_edge (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take_edge),
		.interval  (item.interval),
		.threshold (thr_q),
		.wr        (wr)
	);

	ppmdec_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.rdata  (rdata)
	);

	ppmdec_report u_report (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (take_report),
		.buttons  (item.buttons),
		.analog_a (item.analog_a),
		.analog_b (item.analog_b),
		.offset   (off_q),
		.rdata    (rdata),
		.rd       (rd),
		.busy     (busy),
		.rpt      (report)
	);

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !busy)
		else $error("store written during a report");

	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take_report |=> busy)
		else $error("report transfer did not start the serialiser");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.en && rd.en))
		else $error("store read and write in one cycle");

endmodule

`default_nettype wire

[tb/tb_ppm_channel_decoder_with_report_top.sv]
`timescale 1ns / 100ps

module tb_ppm_channel_decoder_with_report_top;
	import ppmdec_pkg::*;

	// item codes on the mode field
	localparam bit MODE_EDGE   = 1'b0;
	localparam bit MODE_REPORT = 1'b1;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 20;
	localparam int DIRECTED_N    = 24;
	localparam int REPORTED_MAX  = 10;

	typedef struct {
		bit          mode;
		logic [15:0] interval;
		logic [7:0]  buttons;
		logic [15:0] analog_a;
		logic [15:0] analog_b;
		bit          typed;   // channel words below are typed in, not predicted
		logic [15:0] word;
	} stim_row_t;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} report_byte_t;

	logic clk;
	logic arst_n;

	ppmdec_item_if item_ch ();
	ppmdec_byte_if report_ch ();
	ppmdec_cfg_if  cfg_ch ();

	ppm_channel_decoder_with_report_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.report (report_ch),
		.cfg    (cfg_ch)
	);

	// directed part, default thresholds: sync above 20000, offset 2000
	// typed rows are reports straight after reset, every channel reads 0 - 2000 = 0xf830
	stim_row_t directed_rows [DIRECTED_N] = '{
		'{MODE_REPORT, 16'h0000, 8'hff, 16'hffff, 16'h0000, 1'b1, 16'hf830},
		'{MODE_REPORT, 16'hffff, 8'h00, 16'h0000, 16'hffff, 1'b1, 16'hf830},
		'{MODE_EDGE,   16'hffff, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000}, // sync at the top
		'{MODE_EDGE,   16'd20001, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000}, // sync just above
		'{MODE_EDGE,   16'd1000, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},  // pause
		'{MODE_EDGE,   16'd0,    8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},  // pulse of zero
		'{MODE_EDGE,   16'd20000, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000}, // threshold, pause
		'{MODE_EDGE,   16'd20000, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000}, // threshold, pulse
		'{MODE_EDGE,   16'd700,  8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
		'{MODE_EDGE,   16'd2000, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},  // reads back as zero
		'{MODE_EDGE,   16'd500,  8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
		'{MODE_EDGE,   16'd1999, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},  // wraps to 0xffff
		'{MODE_EDGE,   16'd400,  8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
		'{MODE_EDGE,   16'd1500, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
		'{MODE_EDGE,   16'd400,  8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
		'{MODE_EDGE,   16'd1234, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
		'{MODE_EDGE,   16'd400,  8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
		'{MODE_EDGE,   16'd19999, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
		'{MODE_EDGE,   16'd400,  8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
		'{MODE_EDGE,   16'd1700, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},  // last free slot
		'{MODE_EDGE,   16'd400,  8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
		'{MODE_EDGE,   16'd1800, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},  // slots full, dropped
		'{MODE_REPORT, 16'h5555, 8'ha5, 16'h1234, 16'habcd, 1'b0, 16'h0000},
		'{MODE_REPORT, 16'haaaa, 8'h5a, 16'h8000, 16'h0001, 1'b0, 16'h0000}   // state unchanged
	};

	// decoder state as predicted, reset values
	logic [15:0] chan_slots [CHANNELS] = '{default: 16'h0000};
	int          slots_filled = 0;
	bit          pause_due    = 1'b0;
	logic [15:0] sync_thr     = SYNC_THRESHOLD_RST;
	logic [15:0] pulse_offs   = PULSE_OFFSET_RST;

	report_byte_t pending_bytes [$];

	// side information travelling with the item currently offered
	bit          item_typed = 1'b0;
	logic [15:0] item_word  = 16'h0000;

	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	int hold_req          = 0;
	int hold_left         = 0;
	int items_sent        = 0;
	int report_items      = 0;
	int bytes_checked     = 0;
	int fail_count        = 0;
	int cycle_count       = 0;

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= REPORTED_MAX) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
	endfunction

	function automatic void expect_byte(logic [7:0] value, int k);
		report_byte_t rb;
		rb.value = value;
		rb.last  = (k == REPORT_LEN - 1);
		pending_bytes.push_back(rb);
	endfunction

	// decode one transfer on the item channel, queueing any report bytes it causes
	function automatic void decode_ppm_item(bit mode, logic [15:0] iv, logic [7:0] btn,
			logic [15:0] a, logic [15:0] b, bit typed, logic [15:0] typed_word);
		logic [15:0] word;
		logic [15:0] analog [2];
		int k;
		if (mode == MODE_EDGE) begin
			if (iv > sync_thr) begin
				slots_filled = 0;
				pause_due    = 1'b1;
			end else if (pause_due) begin
				pause_due = 1'b0;
			end else begin
				if (slots_filled < CHANNELS) begin
					chan_slots[slots_filled] = iv;
					slots_filled++;
				end
				pause_due = 1'b1;
			end
		end else begin
			analog[0] = a;
			analog[1] = b;
			k = 0;
			expect_byte(btn, k);
			k++;
			for (int i = 0; i < CHANNELS; i++) begin
				word = typed ? typed_word : chan_slots[i] - pulse_offs;
				expect_byte(word[7:0], k);
				k++;
				expect_byte(word[15:8], k);
				k++;
			end
			for (int i = 0; i < ANALOG_INPUTS && i < 2; i++) begin
				expect_byte(analog[i][7:0], k);
				k++;
				expect_byte(analog[i][15:8], k);
				k++;
			end
		end
	endfunction

	function automatic void check_report_byte(logic [7:0] got, logic got_last);
		report_byte_t want;
		if (pending_bytes.size() == 0) begin
			note_failure($sformatf("report byte %02h last %0b with nothing expected",
				got, got_last));
		end else begin
			want = pending_bytes.pop_front();
			bytes_checked++;
			if (got !== want.value || got_last !== want.last) begin
				note_failure($sformatf("report byte expected %02h last %0b, got %02h last %0b",
					want.value, want.last, got, got_last));
			end
		end
	endfunction

	// everything observed at the rising edge, before the edge's own updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					CFG_SYNC_THRESHOLD: sync_thr   = cfg_ch.data;
					CFG_PULSE_OFFSET:   pulse_offs = cfg_ch.data;
					default: ;
				endcase
			end
			if (item_ch.valid && item_ch.ready) begin
				decode_ppm_item(item_ch.mode, item_ch.interval, item_ch.buttons,
					item_ch.analog_a, item_ch.analog_b, item_typed, item_word);
			end
			if (report_ch.valid && report_ch.ready) begin
				check_report_byte(report_ch.report_byte, report_ch.last_byte);
			end
		end
	end

	// report side: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			report_ch.ready <= 1'b0;
			hold_left--;
		end else if (hold_req > 0) begin
			hold_left = hold_req - 1;
			hold_req  = 0;
			report_ch.ready <= 1'b0;
		end else begin
			report_ch.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
		end
	end

	// offer one item and hold it until its transfer; valid is left high for the caller
	task automatic send_item(bit mode, logic [15:0] iv, logic [7:0] btn,
			logic [15:0] a, logic [15:0] b, bit typed, logic [15:0] word);
		if (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		item_ch.valid    <= 1'b1;
		item_ch.mode     <= mode;
		item_ch.interval <= iv;
		item_ch.buttons  <= btn;
		item_ch.analog_a <= a;
		item_ch.analog_b <= b;
		item_typed       <= typed;
		item_word        <= word;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		if (mode == MODE_REPORT) begin
			report_items++;
		end
	endtask

	// a pause or pulse interval that is not a sync under the current threshold
	function automatic logic [15:0] pick_short();
		int thr = sync_thr;
		case ($urandom_range(5, 0))
			0: return 16'h0000;
			1: return 16'(thr);
			default: return 16'($urandom_range(thr, 0));
		endcase
	endfunction

	// only meaningful while the threshold is below the top of the range
	function automatic logic [15:0] pick_sync();
		int thr = sync_thr;
		case ($urandom_range(3, 0))
			0: return 16'hffff;
			1: return 16'(thr + 1);
			default: return 16'($urandom_range(65535, thr + 1));
		endcase
	endfunction

	// mostly a well formed frame: sync, pause/pulse pairs, report
	// now and then a lone noise item, a missing sync or a missing pause
	task automatic send_frame();
		int pairs;
		if ($urandom_range(7, 0) == 0) begin
			send_item(1'($urandom_range(1, 0)), 16'($urandom), 8'($urandom),
				16'($urandom), 16'($urandom), 1'b0, 16'h0000);
			return;
		end
		pairs = $urandom_range(10, 0);
		if (sync_thr != 16'hffff && $urandom_range(9, 0) != 0) begin
			send_item(MODE_EDGE, pick_sync(), 8'($urandom), 16'($urandom), 16'($urandom),
				1'b0, 16'h0000);
		end
		repeat (pairs) begin
			if ($urandom_range(9, 0) != 0) begin
				send_item(MODE_EDGE, pick_short(), 8'($urandom), 16'($urandom),
					16'($urandom), 1'b0, 16'h0000);
			end
			send_item(MODE_EDGE, pick_short(), 8'($urandom), 16'($urandom), 16'($urandom),
				1'b0, 16'h0000);
		end
		send_item(MODE_REPORT, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
			1'b0, 16'h0000);
	endtask

	// wait for every queued byte, then give the last edge item time to land
	task automatic settle();
		do @(posedge clk); while (pending_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int budget);
		int start;
		start = items_sent;
		while (items_sent - start < budget) begin
			send_frame();
		end
		item_ch.valid <= 1'b0;
		settle();
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n           <= 1'b0;
		item_ch.valid    <= 1'b0;
		item_ch.mode     <= MODE_EDGE;
		item_ch.interval <= 16'h0000;
		item_ch.buttons  <= 8'h00;
		item_ch.analog_a <= 16'h0000;
		item_ch.analog_b <= 16'h0000;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= CFG_SYNC_THRESHOLD;
		cfg_ch.data      <= 16'h0000;

		// sender rarely idle, receiver mostly stalled
		sender_idle_pct   = 6;
		receiver_idle_pct = 85;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows straight into the first random stretch at reset settings
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].mode, directed_rows[i].interval,
				directed_rows[i].buttons, directed_rows[i].analog_a,
				directed_rows[i].analog_b, directed_rows[i].typed, directed_rows[i].word);
		end
		run_random(15);

		// lowest threshold: only a zero interval is not a sync; largest offset
		write_reg(CFG_SYNC_THRESHOLD, 16'h0000);
		write_reg(CFG_PULSE_OFFSET, 16'hffff);
		sender_idle_pct   = 85;
		receiver_idle_pct = 6;
		run_random(15);

		// highest threshold: no sync possible, slots fill and stay full; no offset
		write_reg(CFG_SYNC_THRESHOLD, 16'hffff);
		write_reg(CFG_PULSE_OFFSET, 16'h0000);
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		run_random(15);

		// mid-range settings, report side held off so the item side backs up
		write_reg(CFG_SYNC_THRESHOLD, 16'd3000);
		write_reg(CFG_PULSE_OFFSET, 16'd1000);
		hold_req = 150;
		send_item(MODE_REPORT, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
			1'b0, 16'h0000);
		run_random(12);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_bytes.size() != 0) begin
			note_failure($sformatf("%0d report bytes never arrived", pending_bytes.size()));
		end

		$display("%0d items (%0d reports) over four register settings, %0d bytes checked",
			items_sent, report_items, bytes_checked);
		$display("stall mixes on both sides plus one long report hold-off, %0d cycles, %0d failures",
			cycle_count, fail_count);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/ppmdec_pkg.sv
sv/ppmdec_if.sv
sv/ppmdec_store.sv
sv/ppmdec_edge.sv
sv/ppmdec_report.sv
sv/ppm_channel_decoder_with_report_top.sv
tb/tb_ppm_channel_decoder_with_report_top.sv
